/* hdl/pvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pvt_pkg;

  localparam int IDX_W      = 12;
  localparam int COORD_W    = 32;
  localparam int EPOCH_W    = 8;
  localparam int NUM_W      = 62;
  localparam int DEN_W      = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_NEAR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FAR       = 3'd5;

  typedef struct packed {
    logic               new_batch;
    logic               entry_present;
    logic [IDX_W-1:0]   vertex_index;
    logic [COORD_W-1:0] clip_x;
    logic [COORD_W-1:0] clip_y;
    logic [COORD_W-1:0] clip_z;
    logic [COORD_W-1:0] clip_w;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic [15:0]        depth;
    logic               divide_fault;
  } out_item_t;

  // work handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0]   vertex_index;
    logic [COORD_W-1:0] clip_x;
    logic [COORD_W-1:0] clip_y;
    logic [COORD_W-1:0] clip_z;
    logic [COORD_W-1:0] clip_w;
  } job_t;

  typedef struct packed {
    logic [15:0] viewport_x;
    logic [15:0] viewport_y;
    logic [14:0] viewport_width;
    logic [14:0] viewport_height;
    logic [15:0] depth_near;
    logic [15:0] depth_far;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    logic [31:0] r;
    if (v > 65'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -65'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [15:0] sat16u(input logic signed [64:0] v);
    logic [15:0] r;
    if (v < 65'sd0) r = 16'h0000;
    else if (v > 65'sd65535) r = 16'hFFFF;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/pvt_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pvt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/pvt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvt_front #(
  parameter int MAX_BATCH_VERTICES = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  pvt_stream_if.sink   vertex_in,
  pvt_stream_if.source job_out
);

  localparam int AW = (MAX_BATCH_VERTICES > 1) ? $clog2(MAX_BATCH_VERTICES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BATCH_VERTICES - 1);
  localparam logic [pvt_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t                          state;
  pvt_pkg::in_item_t               item;
  logic [pvt_pkg::EPOCH_W-1:0]     epoch;
  logic [pvt_pkg::EPOCH_W-1:0]     epoch_next;
  logic [AW-1:0]                   sweep;
  logic                            pending;
  logic [pvt_pkg::EPOCH_W-1:0]     rd_tag;
  logic [pvt_pkg::EPOCH_W-1:0]     tag_mem [MAX_BATCH_VERTICES];

  logic                            accept;
  logic                            in_map;
  logic                            hit;
  logic                            emit;
  logic                            wrap;
  logic                            leave;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [pvt_pkg::EPOCH_W-1:0]     mem_wdata;

  assign vertex_in.ready = (state == S_IDLE);
  assign accept = vertex_in.valid && vertex_in.ready;

  // lookup decision for the held request
  always_comb begin
    in_map     = 32'(item.vertex_index) < 32'(MAX_BATCH_VERTICES);
    wrap       = item.new_batch && (epoch == EPOCH_MAX);
    epoch_next = item.new_batch ? epoch + 1'b1 : epoch;
    hit        = !item.new_batch && in_map && (rd_tag == epoch);
    emit       = item.entry_present && !hit;
    leave      = (state == S_LOOK) && !wrap && (!emit || job_out.ready);
  end

  assign job_out.valid = (state == S_LOOK) && !wrap && emit;
  assign job_out.data  = '{vertex_index: item.vertex_index, clip_x: item.clip_x,
                           clip_y: item.clip_y, clip_z: item.clip_z,
                           clip_w: item.clip_w};

  // tag memory write: sweep or mark
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (leave && emit && in_map) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(item.vertex_index);
      mem_wdata = epoch_next;
    end
  end

  // visited tags, one epoch mark per vertex
  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[mem_waddr] <= mem_wdata;
    if (accept) rd_tag <= tag_mem[AW'(vertex_in.data.vertex_index)];
  end

  always_ff @(posedge clk) begin
    if (accept) item <= vertex_in.data;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      sweep   <= '0;
      pending <= 1'b0;
      epoch   <= pvt_pkg::EPOCH_W'(1);
    end else begin
      case (state)
        S_CLEAR: begin
          if (sweep == LAST_ADDR) begin
            sweep   <= '0;
            pending <= 1'b0;
            if (pending) begin
              epoch <= '0;
              state <= S_LOOK;
            end else begin
              epoch <= pvt_pkg::EPOCH_W'(1);
              state <= S_IDLE;
            end
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) state <= S_LOOK;
        end
        S_LOOK: begin
          if (wrap) begin
            pending <= 1'b1;
            sweep   <= '0;
            state   <= S_CLEAR;
          end else if (leave) begin
            epoch <= epoch_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> epoch != '0)
    else $error("epoch zero while accepting");
  a_push_present: assert property (@(posedge clk) disable iff (rst)
    job_out.valid |-> item.entry_present && !(state == S_CLEAR))
    else $error("culled entry pushed");
  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) && wrap |=> state == S_CLEAR && sweep == '0)
    else $error("epoch wrap without sweep");

endmodule

`default_nettype wire

/* hdl/pvt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvt_queue (
  input  wire logic clk,
  input  wire logic rst,
  pvt_stream_if.sink   q_in,
  pvt_stream_if.source q_out
);

  localparam int DEPTH = 2;

  pvt_pkg::job_t slot [DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign q_in.ready  = (count != 2'(DEPTH));
  assign q_out.valid = (count != 2'd0);
  assign q_out.data  = slot[rd_ptr];
  assign push = q_in.valid && q_in.ready;
  assign pop  = q_out.valid && q_out.ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= q_in.data;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue overfilled");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step");

endmodule

`default_nettype wire

/* hdl/pvt_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvt_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pvt_pkg::NUM_W-1:0]   num,
  input  wire logic [pvt_pkg::DEN_W-1:0]   den,
  output logic                             busy,
  output logic [pvt_pkg::NUM_W-1:0]        quot,
  output logic                             rem_nz
);

  localparam int CW = $clog2(pvt_pkg::NUM_W + 1);

  logic [pvt_pkg::DEN_W-1:0] rem;
  logic [pvt_pkg::DEN_W-1:0] dvs;
  logic [pvt_pkg::NUM_W-1:0] shreg;
  logic [CW-1:0]             cnt;
  logic [pvt_pkg::DEN_W:0]   trial;
  logic                      take;

  // one restoring step: shift in next numerator bit, try subtract
  always_comb begin
    trial = {rem, shreg[pvt_pkg::NUM_W-1]};
    take  = trial >= {1'b0, dvs};
  end

  assign quot   = shreg;
  assign rem_nz = (rem != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvs   <= den;
      shreg <= num;
    end else if (busy) begin
      rem   <= take ? pvt_pkg::DEN_W'(trial - {1'b0, dvs})
                    : pvt_pkg::DEN_W'(trial);
      shreg <= {shreg[pvt_pkg::NUM_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(pvt_pkg::NUM_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/pvt_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pvt_pkg::cfg_t cfg,
  pvt_stream_if.sink         job_in,
  pvt_stream_if.source       vertex_out
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_ABS  = 6'b000100,
    B_DIV  = 6'b001000,
    B_FLR  = 6'b010000,
    B_SUM  = 6'b100000
  } state_t;

  state_t                state;
  pvt_pkg::job_t         job;
  logic signed [48:0]    px;
  logic signed [48:0]    py;
  logic signed [49:0]    pz;
  logic                  neg_x;
  logic                  neg_y;
  logic                  neg_z;
  logic                  fault;
  logic signed [63:0]    fx;
  logic signed [63:0]    fy;
  logic signed [63:0]    fz;
  logic                  out_valid;
  pvt_pkg::out_item_t    out_data;

  logic signed [32:0]    w33;
  logic signed [32:0]    sum_x;
  logic signed [32:0]    dif_y;
  logic signed [32:0]    sum_z;
  logic signed [16:0]    drange;
  logic [32:0]           w_mag;
  logic signed [63:0]    nx;
  logic signed [63:0]    ny;
  logic signed [63:0]    nz;
  logic [63:0]           mx;
  logic [63:0]           my;
  logic [63:0]           mz;
  logic                  out_free;
  logic signed [64:0]    sx;
  logic signed [64:0]    sy;
  logic signed [64:0]    dd;
  pvt_pkg::out_item_t    res;

  pvt_pkg::div_ctl_t     dctl;
  logic                  busy_y;
  logic                  busy_z;
  logic [pvt_pkg::NUM_W-1:0] qx;
  logic [pvt_pkg::NUM_W-1:0] qy;
  logic [pvt_pkg::NUM_W-1:0] qz;
  logic                  rx;
  logic                  ry;
  logic                  rz;

  assign job_in.ready     = (state == B_IDLE);
  assign vertex_out.valid = out_valid;
  assign vertex_out.data  = out_data;
  assign out_free         = !out_valid || vertex_out.ready;

  // operand preparation
  always_comb begin
    w33    = 33'($signed(job.clip_w));
    sum_x  = w33 + 33'($signed(job.clip_x));
    dif_y  = w33 - 33'($signed(job.clip_y));
    sum_z  = w33 + 33'($signed(job.clip_z));
    drange = $signed({1'b0, cfg.depth_far}) - $signed({1'b0, cfg.depth_near});
    w_mag  = job.clip_w[31] ? 33'(-w33) : 33'(w33);
    nx     = 64'(px) <<< 15;
    ny     = 64'(py) <<< 15;
    nz     = 64'(pz);
    mx     = nx[63] ? 64'(-nx) : 64'(nx);
    my     = ny[63] ? 64'(-ny) : 64'(ny);
    mz     = nz[63] ? 64'(-nz) : 64'(nz);
  end

  assign dctl.start = (state == B_ABS) && (job.clip_w != '0);

  pvt_div u_div_x (
    .clk (clk), .rst (rst), .start (dctl.start),
    .num (mx[pvt_pkg::NUM_W-1:0]), .den (w_mag),
    .busy (dctl.busy), .quot (qx), .rem_nz (rx)
  );
  pvt_div u_div_y (
    .clk (clk), .rst (rst), .start (dctl.start),
    .num (my[pvt_pkg::NUM_W-1:0]), .den (w_mag),
    .busy (busy_y), .quot (qy), .rem_nz (ry)
  );
  pvt_div u_div_z (
    .clk (clk), .rst (rst), .start (dctl.start),
    .num (mz[pvt_pkg::NUM_W-1:0]), .den ({w_mag[31:0], 1'b0}),
    .busy (busy_z), .quot (qz), .rem_nz (rz)
  );

  // final sums and saturation
  always_comb begin
    sx = (65'($signed(cfg.viewport_x)) <<< 16) + 65'(fx);
    sy = (65'($signed(cfg.viewport_y)) <<< 16) + 65'(fy);
    dd = $signed({49'b0, cfg.depth_near}) + 65'(fz);
    res.out_index = job.vertex_index;
    if (fault) begin
      res.screen_x     = job.clip_x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      res.screen_y     = job.clip_y[31] ? 32'h7FFF_FFFF : 32'h8000_0000;
      res.depth        = job.clip_z[31] ? 16'h0000 : 16'hFFFF;
      res.divide_fault = 1'b1;
    end else begin
      res.screen_x     = pvt_pkg::sat32(sx);
      res.screen_y     = pvt_pkg::sat32(sy);
      res.depth        = pvt_pkg::sat16u(dd);
      res.divide_fault = 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_in.valid) job <= job_in.data;
      end
      B_MUL: begin
        px <= $signed({1'b0, cfg.viewport_width}) * sum_x;
        py <= $signed({1'b0, cfg.viewport_height}) * dif_y;
        pz <= drange * sum_z;
      end
      B_ABS: begin
        neg_x <= nx[63] ^ job.clip_w[31];
        neg_y <= ny[63] ^ job.clip_w[31];
        neg_z <= nz[63] ^ job.clip_w[31];
        fault <= (job.clip_w == '0);
      end
      B_FLR: begin
        fx <= neg_x ? -(64'(qx) + 64'(rx)) : 64'(qx);
        fy <= neg_y ? -(64'(qy) + 64'(ry)) : 64'(qy);
        fz <= neg_z ? -(64'(qz) + 64'(rz)) : 64'(qz);
      end
      default: ;
    endcase
    if ((state == B_SUM) && out_free) out_data <= res;
  end

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == B_SUM) && out_free) out_valid <= 1'b1;
      else if (vertex_out.ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: if (job_in.valid) state <= B_MUL;
        B_MUL:  state <= B_ABS;
        B_ABS:  state <= (job.clip_w == '0) ? B_SUM : B_DIV;
        B_DIV:  if (!dctl.busy && !dctl.start) state <= B_FLR;
        B_FLR:  state <= B_SUM;
        B_SUM: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    dctl.busy |-> (busy_y && busy_z && state == B_DIV))
    else $error("dividers out of step");
  a_fault_skip: assert property (@(posedge clk) disable iff (rst)
    (state == B_ABS) && (job.clip_w == '0) |=> state == B_SUM && !dctl.busy)
    else $error("zero w entered divider");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !vertex_out.ready |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* hdl/perspective_viewport_transform_unit.sv */
// A request passes the tag lookup, the two-entry queue, then the multiply,
//   abs, divide, floor and sum stages; the dividers are skipped when w is zero
// The back end works on one request at a time and its shift-subtract dividers
//   retire one quotient bit a cycle; requests with no result stay in the front
// reset: after rst every visited tag is swept before the first request is
//   taken; the same sweep runs once per 255 batches
`timescale 1ns / 1ps
`default_nettype none

module perspective_viewport_transform_unit #(
  parameter int MAX_BATCH_VERTICES = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [pvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pvt_pkg::CFG_DATA_W-1:0]    cfg_data,
  pvt_stream_if.sink                             vertex_in,
  pvt_stream_if.source                           vertex_out
);

  pvt_pkg::cfg_t cfg;

  pvt_stream_if #(.T(pvt_pkg::job_t)) front_q ();
  pvt_stream_if #(.T(pvt_pkg::job_t)) q_back ();

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.viewport_x      <= '0;
      cfg.viewport_y      <= '0;
      cfg.viewport_width  <= '0;
      cfg.viewport_height <= '0;
      cfg.depth_near      <= '0;
      cfg.depth_far       <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        pvt_pkg::REG_VIEWPORT_X:      cfg.viewport_x      <= cfg_data;
        pvt_pkg::REG_VIEWPORT_Y:      cfg.viewport_y      <= cfg_data;
        pvt_pkg::REG_VIEWPORT_WIDTH:  cfg.viewport_width  <= cfg_data[14:0];
        pvt_pkg::REG_VIEWPORT_HEIGHT: cfg.viewport_height <= cfg_data[14:0];
        pvt_pkg::REG_DEPTH_NEAR:      cfg.depth_near      <= cfg_data;
        pvt_pkg::REG_DEPTH_FAR:       cfg.depth_far       <= cfg_data;
        default: ;
      endcase
    end
  end

  pvt_front #(.MAX_BATCH_VERTICES(MAX_BATCH_VERTICES)) u_front (
    .clk (clk), .rst (rst), .vertex_in (vertex_in), .job_out (front_q)
  );

  pvt_queue u_queue (
    .clk (clk), .rst (rst), .q_in (front_q), .q_out (q_back)
  );

  pvt_back u_back (
    .clk (clk), .rst (rst), .cfg (cfg), .job_in (q_back), .vertex_out (vertex_out)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int MAP_DEPTH     = 4096;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int DRAIN_CYCLES  = 200;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [pvt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pvt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pvt_stream_if #(.T(pvt_pkg::in_item_t)) vertex_in ();
  pvt_stream_if #(.T(pvt_pkg::out_item_t)) vertex_out ();

  perspective_viewport_transform_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .vertex_in(vertex_in.sink),
    .vertex_out(vertex_out.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and visited map
  logic signed [15:0] vp_x, vp_y;
  logic [14:0] vp_w, vp_h;
  logic [15:0] dep_near, dep_far;
  bit visited [MAP_DEPTH];

  pvt_pkg::out_item_t screen_queue[$];
  int mismatches = 0;
  longint cycles = 0;

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num >= 0) q = num / den;
    else q = -((-num + den - 1) / den);
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // transform one request, returns 1 when a vertex comes out
  function automatic bit transform_vertex(input pvt_pkg::in_item_t r,
                                          output pvt_pkg::out_item_t o);
    longint cx, cy, cz, cw, sx, sy, d;
    if (r.new_batch) visited = '{default: 1'b0};
    if (!r.entry_present) return 0;
    if (visited[r.vertex_index]) return 0;
    cx = longint'($signed(r.clip_x));
    cy = longint'($signed(r.clip_y));
    cz = longint'($signed(r.clip_z));
    cw = longint'($signed(r.clip_w));
    o.out_index = r.vertex_index;
    if (cw == 0) begin
      o.screen_x = (cx >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      o.screen_y = (cy >= 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      o.depth = (cz >= 0) ? 16'hFFFF : 16'h0000;
      o.divide_fault = 1'b1;
    end else begin
      sx = longint'(vp_x) * 65536 + floor_quot(longint'(vp_w) * (cw + cx) * 32768, cw);
      sy = longint'(vp_y) * 65536 + floor_quot(longint'(vp_h) * (cw - cy) * 32768, cw);
      d = longint'(dep_near) +
          floor_quot((longint'(dep_far) - longint'(dep_near)) * (cw + cz), 2 * cw);
      o.screen_x = 32'(clamp32(sx));
      o.screen_y = 32'(clamp32(sy));
      o.depth = (d < 0) ? 16'h0000 : ((d > 65535) ? 16'hFFFF : 16'(d));
      o.divide_fault = 1'b0;
    end
    visited[r.vertex_index] = 1'b1;
    return 1;
  endfunction

  // random gap, mostly short, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** perspective_viewport_transform_unit: FAILED **");
      $finish;
    end
  end

  // result side: random stalls and check
  int stall_left = 0;
  bit stall_phase = 1'b0;
  initial vertex_out.ready = 1'b0;

  always @(posedge clk) begin
    pvt_pkg::out_item_t want, got;
    if (rst) begin
      vertex_out.ready <= 1'b0;
    end else begin
      if (vertex_out.valid && vertex_out.ready) begin
        got = vertex_out.data;
        if (screen_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected vertex idx=%0d", got.out_index);
        end else begin
          want = screen_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx=%0d x=%h y=%h z=%h f=%b got idx=%0d x=%h y=%h z=%h f=%b",
                       want.out_index, want.screen_x, want.screen_y, want.depth,
                       want.divide_fault, got.out_index, got.screen_x, got.screen_y,
                       got.depth, got.divide_fault);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_phase <= ~stall_phase;
        stall_left <= stall_phase ? $urandom_range(0, 6) : gap_len();
        vertex_out.ready <= stall_phase;
      end
    end
  end

  task automatic write_reg(input logic [pvt_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      pvt_pkg::REG_VIEWPORT_X: vp_x = val;
      pvt_pkg::REG_VIEWPORT_Y: vp_y = val;
      pvt_pkg::REG_VIEWPORT_WIDTH: vp_w = val[14:0];
      pvt_pkg::REG_VIEWPORT_HEIGHT: vp_h = val[14:0];
      pvt_pkg::REG_DEPTH_NEAR: dep_near = val;
      pvt_pkg::REG_DEPTH_FAR: dep_far = val;
      default: ;
    endcase
  endtask

  task automatic set_viewport(input logic [15:0] x, y, w, h, n, f);
    write_reg(pvt_pkg::REG_VIEWPORT_X, x);
    write_reg(pvt_pkg::REG_VIEWPORT_Y, y);
    write_reg(pvt_pkg::REG_VIEWPORT_WIDTH, w);
    write_reg(pvt_pkg::REG_VIEWPORT_HEIGHT, h);
    write_reg(pvt_pkg::REG_DEPTH_NEAR, n);
    write_reg(pvt_pkg::REG_DEPTH_FAR, f);
    cfg_write <= 1'b0;
  endtask

  // wait until every expected vertex is back, then let the pipe settle
  task automatic drain();
    vertex_in.valid <= 1'b0;
    while (screen_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one request, with predicted or typed-in expectation
  task automatic send_request(input pvt_pkg::in_item_t r, input bit fixed,
                              input pvt_pkg::out_item_t fixed_exp);
    pvt_pkg::out_item_t o;
    int g;
    g = gap_len();
    if (g > 0) begin
      vertex_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vertex_in.valid <= 1'b1;
    vertex_in.data <= r;
    @(posedge clk);
    while (!vertex_in.ready) @(posedge clk);
    if (transform_vertex(r, o)) screen_queue.push_back(fixed ? fixed_exp : o);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_w();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 32'h0;
    if (p == 1) return $urandom();
    if (p < 4) return 32'($signed(-$urandom_range(1, 4 << 16)));
    return 32'($urandom_range(1, 4 << 16));
  endfunction

  typedef struct {
    pvt_pkg::in_item_t req;
    bit fixed;
    pvt_pkg::out_item_t exp;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic pvt_pkg::in_item_t mk(bit nb, bit pr, logic [11:0] idx,
                                           logic [31:0] x, y, z, w);
    pvt_pkg::in_item_t r;
    r = '{nb, pr, idx, x, y, z, w};
    return r;
  endfunction

  initial begin
    pvt_pkg::in_item_t r;
    pvt_pkg::out_item_t none;
    int batch_left;
    logic [11:0] base;
    vp_x = 0; vp_y = 0; vp_w = 0; vp_h = 0; dep_near = 0; dep_far = 16'hFFFF;
    none = '0;
    vertex_in.valid = 1'b0;
    vertex_in.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, defaults after reset give zero viewport
    directed.push_back('{mk(1, 1, 12'd0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000),
                         1, '{12'd0, 32'h0, 32'h0, 16'h7FFF, 1'b0}});
    directed.push_back('{mk(0, 1, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0),
                         1, '{12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1}});
    directed.push_back('{mk(0, 1, 12'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0),
                         1, '{12'd1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b1}});
    // repeated vertex and culled entry give nothing
    directed.push_back('{mk(0, 1, 12'd1, 32'h0, 32'h0, 32'h0, 32'h1), 0, none});
    directed.push_back('{mk(0, 0, 12'd7, 32'h0, 32'h0, 32'h0, 32'h1), 0, none});
    // culled entry still starts a new batch
    directed.push_back('{mk(1, 0, 12'd1, 32'h0, 32'h0, 32'h0, 32'h1), 0, none});
    directed.push_back('{mk(0, 1, 12'd1, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0001_0000),
                         0, none});
    foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].exp);
    drain();

    // extremes of the registers, far below near
    set_viewport(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
    send_request(mk(1, 1, 12'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001),
                 0, none);
    send_request(mk(0, 1, 12'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000),
                 0, none);
    send_request(mk(0, 1, 12'd5, 32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'hFFFF_0000), 0, none);
    send_request(mk(0, 1, 12'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0), 0, none);
    drain();

    // random phases, each with its own viewport setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_viewport(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF);
      else set_viewport(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 32767)),
                        16'($urandom_range(0, 32767)), 16'($urandom()), 16'($urandom()));
      batch_left = 0;
      base = 0;
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        // mostly small batches revisiting a handful of indexes
        if (batch_left == 0) begin
          batch_left = $urandom_range(4, 40);
          base = 12'($urandom());
          r = mk(1, $urandom_range(0, 9) != 0, base, rand_coord(), rand_coord(),
                 rand_coord(), rand_w());
        end else begin
          r = mk($urandom_range(0, 49) == 0, $urandom_range(0, 9) != 0,
                 ($urandom_range(0, 4) == 0) ? 12'($urandom()) : base + 12'($urandom_range(0, 15)),
                 rand_coord(), rand_coord(), rand_coord(), rand_w());
        end
        batch_left--;
        send_request(r, 0, none);
        // hold off until the pipe is empty once per phase
        if (n == 100) begin
          vertex_in.valid <= 1'b0;
          while (screen_queue.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0 && screen_queue.size() == 0)
      $display("** perspective_viewport_transform_unit: PASSED **");
    else
      $display("** perspective_viewport_transform_unit: FAILED **");
    $finish;
  end

endmodule
